FILE: sv/mkt_pkg.sv
// Package for the MRU keyed table: sizes, operation codes, item types and controller types.
`default_nettype none

package mkt_pkg;

    // Table geometry
    localparam int CAPACITY = 8;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 64;
    localparam int POS_W     = 3;
    localparam int TOTAL_W   = 4;

    // Operation codes; the fourth code behaves as a lookup without payload
    localparam logic [FUNC_W-1:0] FN_LOOKUP   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMEMBER = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FORGET   = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     position;
        logic [PAYLOAD_W-1:0] stored_payload;
        logic [TOTAL_W-1:0]   entry_total;
        logic                 evicted;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // search, update the table, register the result
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/mru_keyed_table_unit.sv
// Top level of the MRU keyed table: controller and datapath.
`default_nettype none

// Most-recently-used table of up to eight key/payload entries kept in recency
// order, newest at position 0. An item is taken when start is high and busy is
// low; busy then stays high while all valid entries are compared at once and
// a remember or a forget shifts entries by one place. The result appears on o_result
// with o_strobe high for exactly one cycle, starting as busy falls again,
// and must be captured at the edge that ends that cycle: there is no way to
// hold it. A new item may be offered
// in the cycle the result is shown; no item is taken while busy is high,
// so each item waits for the search and shift of the one before. Lookup
// returns the payload of a present key; remember moves or inserts the key
// at the front, dropping the oldest entry when full (flagged by evicted);
// forget removes the key and closes the gap. A zero key changes nothing.
// entry_total always gives the count after the operation.

module mru_keyed_table_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mkt_pkg::t_in_item i_item,
    output mkt_pkg::t_out_item     o_result,
    output logic                   o_strobe
);

    mkt_pkg::t_cmd w_cmd;

    mkt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    mkt_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

`default_nettype wire

FILE: sv/mkt_ctrl.sv
// Controller state machine for the MRU keyed table.
`default_nettype none

module mkt_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output mkt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    mkt_pkg::t_state r_state;
    mkt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mkt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = mkt_pkg::ST_EXEC;
                end
            end
            mkt_pkg::ST_EXEC: begin
                n_state = mkt_pkg::ST_IDLE;
            end
            default: begin
                n_state = mkt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_busy     = 1'b0;
        case (r_state)
            mkt_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
            end
            mkt_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_busy     = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/mkt_datapath.sv
// Datapath for the MRU keyed table: entry registers, parallel key match, shift update, result.
`default_nettype none

module mkt_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mkt_pkg::t_cmd     i_cmd,
    input  wire mkt_pkg::t_in_item i_item,
    output mkt_pkg::t_out_item     o_result,
    output logic                   o_strobe
);

    localparam int CAP = mkt_pkg::CAPACITY;
    localparam int KB  = mkt_pkg::KEY_BITS;
    localparam int IW  = mkt_pkg::IDX_W;
    localparam int CW  = mkt_pkg::CNT_W;
    localparam int PW  = mkt_pkg::PAYLOAD_W;

    mkt_pkg::t_in_item  r_op;
    logic [KB-1:0]      r_key [CAP];
    logic [PW-1:0]      r_pay [CAP];
    logic [CW-1:0]      r_count;
    mkt_pkg::t_out_item r_res;
    logic               r_strobe;

    logic [KB-1:0]      n_key [CAP];
    logic [PW-1:0]      n_pay [CAP];
    logic [CW-1:0]      n_count;
    mkt_pkg::t_out_item n_res;

    logic [KB-1:0]      w_key;
    logic               w_key_nz;
    logic [CAP-1:0]     w_match;
    logic               w_found;
    logic [IW-1:0]      w_at;
    logic               w_full;
    logic [IW-1:0]      w_slot;
    logic               w_remember;
    logic               w_forget;

    assign w_key    = r_op.key[KB-1:0];
    assign w_key_nz = |w_key;
    assign w_full   = (r_count == CW'(CAP));

    // Compare against every valid entry at once; lowest index wins
    always_comb begin
        w_found = 1'b0;
        w_at    = '0;
        for (int i = 0; i < CAP; i++) begin
            w_match[i] = (CW'(i) < r_count) && (r_key[i] == w_key);
        end
        for (int i = CAP - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found = 1'b1;
                w_at    = IW'(i);
            end
        end
    end

    assign w_remember = w_key_nz && (r_op.func == mkt_pkg::FN_REMEMBER);
    assign w_forget   = w_key_nz && (r_op.func == mkt_pkg::FN_FORGET) && w_found;

    // Deepest slot the remember shift reaches
    always_comb begin
        if (w_found) begin
            w_slot = w_at;
        end else if (!w_full) begin
            w_slot = IW'(r_count);
        end else begin
            w_slot = IW'(CAP - 1);
        end
    end

    // Entry update
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_key[i] = r_key[i];
            n_pay[i] = r_pay[i];
            if (w_remember) begin
                if (i == 0) begin
                    n_key[i] = w_key;
                    n_pay[i] = r_op.payload;
                end else if (IW'(i) <= w_slot) begin
                    n_key[i] = r_key[(i + CAP - 1) % CAP];
                    n_pay[i] = r_pay[(i + CAP - 1) % CAP];
                end
            end else if (w_forget) begin
                if ((IW'(i) >= w_at) && (CW'(i + 1) < r_count)) begin
                    n_key[i] = r_key[(i + 1) % CAP];
                    n_pay[i] = r_pay[(i + 1) % CAP];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_remember && !w_found && !w_full) begin
            n_count = r_count + CW'(1);
        end else if (w_forget) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_res.found          = w_key_nz && w_found;
        n_res.position       = (w_key_nz && w_found) ? mkt_pkg::POS_W'(w_at) : '0;
        n_res.stored_payload = '0;
        if (w_key_nz && w_found && (r_op.func == mkt_pkg::FN_LOOKUP)) begin
            n_res.stored_payload = r_pay[w_at];
        end
        n_res.entry_total    = mkt_pkg::TOTAL_W'(n_count);
        n_res.evicted        = w_remember && !w_found && w_full;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_item;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
            for (int i = 0; i < CAP; i++) begin
                r_key[i] <= n_key[i];
                r_pay[i] <= n_pay[i];
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

FILE: bench/mru_keyed_table_unit_tb.sv
// Self-checking testbench for the MRU keyed table: directed rows, random phases, mirror model.
`default_nettype none

module mru_keyed_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mkt_pkg::*;

    // Fourth operation code: the package leaves it unnamed, it acts as a bare lookup
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int PHASE_ITEMS = 220;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    t_out_item o_result;
    logic      o_strobe;

    mru_keyed_table_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    // Mirror of the table contents, newest entry at index 0
    logic [KEY_W-1:0]     mirror_keys [CAPACITY];
    logic [PAYLOAD_W-1:0] mirror_payloads [CAPACITY];
    int                   mirror_count;

    // Results still owed by the block, oldest first
    t_out_item pending_results[$];

    typedef struct {
        t_in_item  op;
        bit        known;   // want was typed in by hand
        t_out_item want;
    } dir_row_t;
    dir_row_t dir_rows[$];

    int idle_pct;
    int items_sent;
    int results_seen;
    int hits_seen;
    int evictions_seen;
    int mismatches;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one operation to the mirror and return the result it should produce.
    function automatic t_out_item mru_apply(t_in_item op);
        logic [KEY_W-1:0] k;
        int               hit;
        int               slot;
        t_out_item        res;
        k   = op.key & KEY_MASK;
        hit = -1;
        res = '0;
        for (int i = 0; i < mirror_count; i++) begin
            if (hit < 0 && (mirror_keys[i] & KEY_MASK) == k) hit = i;
        end
        // Zero key: nothing happens, only the count is reported
        if (k != '0) begin
            if (hit >= 0) begin
                res.found    = 1'b1;
                res.position = hit[POS_W-1:0];
            end
            case (op.func)
                FN_LOOKUP: begin
                    if (hit >= 0) res.stored_payload = mirror_payloads[hit];
                end
                FN_REMEMBER: begin
                    if (hit >= 0) begin
                        slot = hit;
                    end else if (mirror_count < CAPACITY) begin
                        slot = mirror_count;
                        mirror_count++;
                    end else begin
                        // full: the oldest entry falls off the end
                        slot = CAPACITY - 1;
                        res.evicted = 1'b1;
                    end
                    for (int i = slot; i > 0; i--) begin
                        mirror_keys[i]     = mirror_keys[i-1];
                        mirror_payloads[i] = mirror_payloads[i-1];
                    end
                    mirror_keys[0]     = k;
                    mirror_payloads[0] = op.payload;
                end
                FN_FORGET: begin
                    if (hit >= 0) begin
                        for (int i = hit; i + 1 < mirror_count; i++) begin
                            mirror_keys[i]     = mirror_keys[i+1];
                            mirror_payloads[i] = mirror_payloads[i+1];
                        end
                        mirror_count--;
                        mirror_keys[mirror_count]     = '0;
                        mirror_payloads[mirror_count] = '0;
                    end
                end
                default: begin
                    // spare code: reports found and position, changes nothing
                end
            endcase
        end
        res.entry_total = mirror_count[TOTAL_W-1:0];
        return res;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] func, input logic [63:0] key,
                           input logic [63:0] payload, input int known,
                           input int found, input int pos,
                           input int total, input int evicted);
        dir_row_t row;
        row.op.func             = func;
        row.op.key              = key;
        row.op.payload          = payload;
        row.known               = (known != 0);
        row.want.found          = (found != 0);
        row.want.position       = POS_W'(pos);
        row.want.stored_payload = '0;
        row.want.entry_total    = TOTAL_W'(total);
        row.want.evicted        = (evicted != 0);
        dir_rows.push_back(row);
    endtask

    // Offer one item from a falling edge, hold it until taken, then maybe idle.
    // start stays high when the next item follows right away.
    task automatic send_item(input t_in_item op, input bit known, input t_out_item want);
        t_out_item pred;
        start  = 1'b1;
        i_item = op;
        do @(posedge i_clk); while (busy);
        pred = mru_apply(op);
        pending_results.push_back(known ? want : pred);
        items_sent++;
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain_pending();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Results are shown for one cycle only; take them at the edge that ends it
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (o_result.found === 1'b1) hits_seen++;
            if (o_result.evicted === 1'b1) evictions_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, got %h",
                         $time, o_result);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 64'(want.found), 64'(o_result.found));
                check_field("position", 64'(want.position), 64'(o_result.position));
                check_field("stored_payload", want.stored_payload, o_result.stored_payload);
                check_field("entry_total", 64'(want.entry_total), 64'(o_result.entry_total));
                check_field("evicted", 64'(want.evicted), 64'(o_result.evicted));
            end
        end
    end

    initial begin : stimulus
        t_in_item         op;
        t_out_item        none;
        logic [KEY_W-1:0] key_pool [16];
        int               pool_size;
        int               rem_pct;
        int               fgt_pct;
        int               r;
        int               counted;
        int               waited;

        start          = 1'b0;
        i_item         = '0;
        i_rst_n        = 1'b0;
        none           = '0;
        mirror_count   = 0;
        items_sent     = 0;
        results_seen   = 0;
        hits_seen      = 0;
        evictions_seen = 0;
        mismatches     = 0;
        idle_pct       = 33;
        for (int i = 0; i < CAPACITY; i++) begin
            mirror_keys[i]     = '0;
            mirror_payloads[i] = '0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows. Typed rows: empty table, zero key, spare code, first
        // inserts, a hit, first eviction. The rest lean on the mirror.
        add_row(FN_LOOKUP,   64'd1,   64'd0,    1, 0, 0, 0, 0);  // empty table
        add_row(FN_FORGET,   64'd1,   64'd0,    1, 0, 0, 0, 0);  // forget absent
        add_row(FN_REMEMBER, 64'd0,   ALL_ONES, 1, 0, 0, 0, 0);  // zero key ignored
        add_row(FN_SPARE,    64'd5,   ALL_ONES, 1, 0, 0, 0, 0);  // spare code, empty
        add_row(FN_REMEMBER, ALL_ONES, 64'd0,   1, 0, 0, 1, 0);  // widest key
        add_row(FN_REMEMBER, 64'd1,   ALL_ONES, 1, 0, 0, 2, 0);  // widest payload
        add_row(FN_LOOKUP,   ALL_ONES, 64'd0,   1, 1, 1, 2, 0);
        add_row(FN_REMEMBER, 64'd2,   64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'd3,   64'hFEDC_BA98_7654_3210, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'd9,   64'd77,   1, 0, 0, 8, 1);  // full: oldest dropped
        add_row(FN_LOOKUP,   ALL_ONES, 64'd0,   0, 0, 0, 0, 0);  // evicted key is gone
        add_row(FN_LOOKUP,   64'd1,   64'd0,    0, 0, 0, 0, 0);  // hit at the back
        add_row(FN_SPARE,    64'd1,   ALL_ONES, 0, 0, 0, 0, 0);
        add_row(FN_REMEMBER, 64'd1,   64'd0,    0, 0, 0, 0, 0);  // move to front
        add_row(FN_REMEMBER, 64'd9,   ALL_ONES, 0, 0, 0, 0, 0);
        add_row(FN_FORGET,   64'h5555_5555_5555_5555, 64'd0, 0, 0, 0, 0, 0);  // middle
        add_row(FN_FORGET,   64'd2,   64'd0,    0, 0, 0, 0, 0);  // last entry
        add_row(FN_FORGET,   64'd2,   64'd0,    0, 0, 0, 0, 0);  // now absent
        add_row(FN_LOOKUP,   64'd0,   ALL_ONES, 0, 0, 0, 0, 0);  // zero key lookup
        add_row(FN_LOOKUP,   64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 0, 0, 0, 0, 0);

        foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].known, dir_rows[i].want);
        drain_pending();

        // Random phases: a small pool of keys keeps hits, moves and evictions
        // frequent; a few fully random and near-miss keys exercise every bit.
        // Each phase ends with the sender holding off until all results are in.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin pool_size = 12; rem_pct = 45; fgt_pct = 15; idle_pct = 33; end
                1: begin pool_size = 4;  rem_pct = 35; fgt_pct = 30; idle_pct = 33; end
                2: begin pool_size = 16; rem_pct = 60; fgt_pct = 5;  idle_pct = 0;  end
                3: begin pool_size = 9;  rem_pct = 40; fgt_pct = 25; idle_pct = 33; end
                4: begin pool_size = 3;  rem_pct = 20; fgt_pct = 50; idle_pct = 33; end
                default: begin pool_size = 10; rem_pct = 40; fgt_pct = 20; idle_pct = 33; end
            endcase
            for (int i = 0; i < 16; i++) begin
                key_pool[i] = {$urandom, $urandom};
                if (key_pool[i] == '0) key_pool[i] = 64'd1;
            end

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 4)                          op.func = FN_SPARE;
                else if (r < 4 + rem_pct)           op.func = FN_REMEMBER;
                else if (r < 4 + rem_pct + fgt_pct) op.func = FN_FORGET;
                else                                op.func = FN_LOOKUP;

                r = $urandom_range(99);
                if (r < 3)       op.key = '0;
                else if (r < 8)  op.key = {$urandom, $urandom};
                else if (r < 12) op.key = key_pool[$urandom_range(pool_size - 1)]
                                          ^ (64'd1 << $urandom_range(63));
                else             op.key = key_pool[$urandom_range(pool_size - 1)];

                r = $urandom_range(99);
                if (r < 3)      op.payload = '0;
                else if (r < 6) op.payload = ALL_ONES;
                else            op.payload = {$urandom, $urandom};

                send_item(op, 1'b0, none);
                if ((op.key & KEY_MASK) != '0) counted++;
            end
            drain_pending();
        end

        // Let any late strobe show up before judging leftovers
        start  = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more, got none",
                     $time, pending_results.size());
            mismatches++;
        end

        $display("Ran %0d items (24 directed, six random phases), %0d results checked",
                 items_sent, results_seen);
        $display("Saw %0d hits and %0d evictions; %0d mismatches",
                 hits_seen, evictions_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under 20 us
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/mkt_pkg.sv
sv/mkt_ctrl.sv
sv/mkt_datapath.sv
sv/mru_keyed_table_unit.sv
bench/mru_keyed_table_unit_tb.sv
